>>> rtl/idrp_pkg.sv
// ----------------------------------------------------------------------------
// idrp_pkg
// Types and constants shared by the IDE ROM paging block.
// ----------------------------------------------------------------------------
package idrp_pkg;

    localparam int CTRL_W     = 8;
    localparam int CONMEM_BIT = 7;
    localparam int MAPRAM_BIT = 6;

    // port decode: 101x_xx11 selects a task-file register
    localparam logic [2:0] PORT_HI_MATCH = 3'b101;
    localparam logic [1:0] PORT_LO_MATCH = 2'b11;
    localparam logic [2:0] IDX_CMD_STAT  = 3'd7;

    typedef enum logic [2:0] {
        OP_CTRL_WRITE = 3'd0,
        OP_AUTOMAP    = 3'd1,
        OP_SOFT_RESET = 3'd2,
        OP_HARD_RESET = 3'd3,
        OP_PORT_DEC   = 3'd4
    } t_op;

    typedef enum logic [0:0] {
        CFG_ENABLED  = 1'b0,
        CFG_WPROTECT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic enabled;
        logic wprotect;
    } t_cfg;

    typedef struct packed {
        logic [CTRL_W-1:0] ctrl;
        logic              automap;
        logic              active;
    } t_state;

    typedef struct packed {
        logic       paged_in;
        logic       bank0_source;
        logic       bank0_writable;
        logic [1:0] bank1_page;
        logic       bank1_writable;
        logic [2:0] ide_register_index;
        logic       ide_attached;
    } t_result;

endpackage

>>> rtl/idrp_ctrl.sv
// ----------------------------------------------------------------------------
// idrp_ctrl
// Control register, automap and paged-in flags with their next-state logic.
// ----------------------------------------------------------------------------
module idrp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_operation,
    input  logic [7:0]          i_control_value,
    input  logic                i_automap_level,
    input  idrp_pkg::t_cfg      i_cfg,
    output idrp_pkg::t_state    o_next
);
    import idrp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   apply;

    always_comb begin
        n_state = r_state;
        apply   = 1'b0;
        case (t_op'(i_operation))
            OP_CTRL_WRITE: begin
                if (i_cfg.enabled) begin
                    n_state.ctrl             = i_control_value;
                    n_state.ctrl[MAPRAM_BIT] = i_control_value[MAPRAM_BIT]
                                             | r_state.ctrl[MAPRAM_BIT];
                    apply = 1'b1;
                end
            end
            OP_AUTOMAP: begin
                n_state.automap = i_automap_level;
                apply = 1'b1;
            end
            OP_SOFT_RESET, OP_HARD_RESET: begin
                n_state.active = 1'b0;
                if (i_cfg.enabled) begin
                    n_state.ctrl = '0;
                    if (t_op'(i_operation) == OP_SOFT_RESET) begin
                        n_state.ctrl[MAPRAM_BIT] = r_state.ctrl[MAPRAM_BIT];
                    end
                    n_state.automap = 1'b0;
                    apply = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (apply) begin
            if (n_state.ctrl[CONMEM_BIT]) begin
                n_state.active = 1'b1;
            end else if (i_cfg.wprotect || n_state.ctrl[MAPRAM_BIT]) begin
                n_state.active = n_state.automap;
            end else begin
                n_state.active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign o_next = n_state;

endmodule

>>> rtl/idrp_map.sv
// ----------------------------------------------------------------------------
// idrp_map
// Bank mapping and IDE port decode from the updated paging state.
// ----------------------------------------------------------------------------
module idrp_map #(
    parameter int RAM_PAGES = 4
) (
    input  idrp_pkg::t_state  i_state,
    input  idrp_pkg::t_cfg    i_cfg,
    input  logic [2:0]        i_operation,
    input  logic [7:0]        i_port_low,
    output idrp_pkg::t_result o_result
);
    import idrp_pkg::*;

    localparam int PW      = $clog2(RAM_PAGES);
    localparam int ENTRIES = 1 << CTRL_W;

    logic [PW-1:0] page_tab [ENTRIES];
    logic [PW-1:0] page;

    // control byte mod page count, fixed at elaboration
    for (genvar g = 0; g < ENTRIES; g++) begin : g_tab
        assign page_tab[g] = PW'(g % RAM_PAGES);
    end

    assign page = page_tab[i_state.ctrl];

    always_comb begin
        o_result          = '0;
        o_result.paged_in = i_state.active;
        if (i_state.active) begin
            o_result.bank1_page = page[1:0];
            if (i_state.ctrl[CONMEM_BIT]) begin
                o_result.bank0_writable = ~i_cfg.wprotect;
                o_result.bank1_writable = 1'b1;
            end else if (i_state.ctrl[MAPRAM_BIT]) begin
                o_result.bank0_source   = 1'b1;
                o_result.bank1_writable = (page != PW'(3));
            end else begin
                o_result.bank1_writable = 1'b1;
            end
        end
        if (t_op'(i_operation) == OP_PORT_DEC) begin
            o_result.ide_attached = i_cfg.enabled;
            if (i_port_low[7:5] == PORT_HI_MATCH && i_port_low[1:0] == PORT_LO_MATCH) begin
                o_result.ide_register_index = i_port_low[4:2];
            end else begin
                o_result.ide_register_index = IDX_CMD_STAT;
            end
        end
    end

endmodule

>>> rtl/ide_interface_rom_paging.sv
// ----------------------------------------------------------------------------
// ide_interface_rom_paging
// ROM paging logic of an IDE interface: control register, automap, bank map.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall | operation and operands
//   out     | output    | o_out_valid / i_out_stall | paging state, IDE decode
//   cfg     | input     | i_cfg_valid / o_cfg_ready | register index, data
//
// One word per cycle while the input is not stalled; the result appears in the
// cycle after acceptance, from the single result register. The input stalls
// only while a result is held by a stalled output. Synchronous active-low
// reset clears state and config; config is always ready.
// ----------------------------------------------------------------------------
module ide_interface_rom_paging #(
    parameter int RAM_PAGES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_control_value,
    input  logic       i_automap_level,
    input  logic [7:0] i_port_low,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_paged_in,
    output logic       o_bank0_source,
    output logic       o_bank0_writable,
    output logic [1:0] o_bank1_page,
    output logic       o_bank1_writable,
    output logic [2:0] o_ide_register_index,
    output logic       o_ide_attached,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data
);
    import idrp_pkg::*;

    t_cfg    r_cfg;
    t_state  next_state;
    t_result result;
    t_result r_result;
    logic    r_out_valid;
    logic    accept;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLED:  r_cfg.enabled  <= i_cfg_data;
                CFG_WPROTECT: r_cfg.wprotect <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    idrp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_operation     (i_operation),
        .i_control_value (i_control_value),
        .i_automap_level (i_automap_level),
        .i_cfg           (r_cfg),
        .o_next          (next_state)
    );

    idrp_map #(
        .RAM_PAGES (RAM_PAGES)
    ) u_map (
        .i_state     (next_state),
        .i_cfg       (r_cfg),
        .i_operation (i_operation),
        .i_port_low  (i_port_low),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_paged_in           = r_result.paged_in;
    assign o_bank0_source       = r_result.bank0_source;
    assign o_bank0_writable     = r_result.bank0_writable;
    assign o_bank1_page         = r_result.bank1_page;
    assign o_bank1_writable     = r_result.bank1_writable;
    assign o_ide_register_index = r_result.ide_register_index;
    assign o_ide_attached       = r_result.ide_attached;

endmodule

>>> sim/ide_interface_rom_paging_check.sv
// ----------------------------------------------------------------------------
// ide_interface_rom_paging_check
// Watches the input, output and register channels of the IDE ROM paging
// block. It keeps its own copy of the control register, the automap and
// paged-in flags and the two settings. From these it works out the paging
// word that each accepted input word should produce, and compares each
// returned word with the oldest one still waiting.
// ----------------------------------------------------------------------------
module ide_interface_rom_paging_check #(
    parameter int RAM_PAGES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_control_value,
    input  logic       i_automap_level,
    input  logic [7:0] i_port_low,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_paged_in,
    input  logic       i_bank0_source,
    input  logic       i_bank0_writable,
    input  logic [1:0] i_bank1_page,
    input  logic       i_bank1_writable,
    input  logic [2:0] i_ide_register_index,
    input  logic       i_ide_attached,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data,
    output int         o_error_count,
    output int         o_pending
);
    import idrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    t_result           expected_maps[$];
    logic [CTRL_W-1:0] ctrl_r;
    logic              automap_r;
    logic              active_r;
    logic              enabled_r;
    logic              wprotect_r;
    int                errors = 0;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
    end

    task automatic report_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_failure($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    function automatic void update_paging();
        if (ctrl_r[CONMEM_BIT]) begin
            active_r = 1'b1;
        end else if (wprotect_r || ctrl_r[MAPRAM_BIT]) begin
            active_r = automap_r;
        end else begin
            active_r = 1'b0;
        end
    endfunction

    function automatic t_result next_mapping(input logic [2:0] op, input logic [7:0] cv,
                                             input logic al, input logic [7:0] pl);
        t_result r;
        logic    keep;
        int      page;
        r    = '0;
        keep = ctrl_r[MAPRAM_BIT];
        case (op)
            OP_CTRL_WRITE: begin
                if (enabled_r) begin
                    ctrl_r             = cv;
                    ctrl_r[MAPRAM_BIT] = ctrl_r[MAPRAM_BIT] | keep;
                    update_paging();
                end
            end
            OP_AUTOMAP: begin
                automap_r = al;
                update_paging();
            end
            OP_SOFT_RESET, OP_HARD_RESET: begin
                active_r = 1'b0;
                if (enabled_r) begin
                    ctrl_r = '0;
                    if (op != OP_HARD_RESET)
                        ctrl_r[MAPRAM_BIT] = keep;
                    automap_r = 1'b0;
                    update_paging();
                end
            end
            OP_PORT_DEC: begin
                if (pl[7:5] == PORT_HI_MATCH && pl[1:0] == PORT_LO_MATCH)
                    r.ide_register_index = pl[4:2];
                else
                    r.ide_register_index = IDX_CMD_STAT;
                r.ide_attached = enabled_r;
            end
            default: ;
        endcase
        if (active_r) begin
            page         = int'(ctrl_r) % RAM_PAGES;
            r.paged_in   = 1'b1;
            r.bank1_page = page[1:0];
            if (ctrl_r[CONMEM_BIT]) begin
                r.bank0_writable = !wprotect_r;
                r.bank1_writable = 1'b1;
            end else if (ctrl_r[MAPRAM_BIT]) begin
                r.bank0_source   = 1'b1;
                r.bank1_writable = (page != 3);
            end else begin
                r.bank1_writable = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            ctrl_r     = '0;
            automap_r  = 1'b0;
            active_r   = 1'b0;
            enabled_r  = 1'b0;
            wprotect_r = 1'b0;
            expected_maps.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ENABLED)
                    enabled_r = i_cfg_data;
                else
                    wprotect_r = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_maps.size() == 0) begin
                    report_failure("output word with nothing expected");
                end else begin
                    want = expected_maps.pop_front();
                    check_field("paged_in", 8'(i_paged_in), 8'(want.paged_in));
                    check_field("bank0_source", 8'(i_bank0_source), 8'(want.bank0_source));
                    check_field("bank0_writable", 8'(i_bank0_writable),
                                8'(want.bank0_writable));
                    check_field("bank1_page", 8'(i_bank1_page), 8'(want.bank1_page));
                    check_field("bank1_writable", 8'(i_bank1_writable),
                                8'(want.bank1_writable));
                    check_field("ide_register_index", 8'(i_ide_register_index),
                                8'(want.ide_register_index));
                    check_field("ide_attached", 8'(i_ide_attached), 8'(want.ide_attached));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_maps.push_back(next_mapping(i_operation, i_control_value,
                                                     i_automap_level, i_port_low));
        end
        o_pending     <= expected_maps.size();
        o_error_count <= errors;
    end

endmodule

>>> sim/ide_interface_rom_paging_test.sv
// ----------------------------------------------------------------------------
// ide_interface_rom_paging_test
// Drives the IDE ROM paging block through a short directed sequence and
// several phases of random words, under every setting of the enable and
// write-protect registers, with random gaps on both sides and long output
// hold-offs. The checker beside the block predicts and compares each word.
// ----------------------------------------------------------------------------
module ide_interface_rom_paging_test;
    import idrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RAM_PAGES      = 4;
    localparam int         IDLE_LIMIT     = 500;
    localparam int         PHASE_WORDS    = 120;
    localparam int         N_PHASES       = 8;
    localparam int         HOLD_CYCLES    = 40;
    localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

    localparam bit PHASE_EN [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam bit PHASE_WP [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [2:0] i_operation;
    logic [7:0] i_control_value;
    logic       i_automap_level;
    logic [7:0] i_port_low;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_paged_in;
    logic       o_bank0_source;
    logic       o_bank0_writable;
    logic [1:0] o_bank1_page;
    logic       o_bank1_writable;
    logic [2:0] o_ide_register_index;
    logic       o_ide_attached;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic       i_cfg_data;

    int error_count;
    int pending;
    bit no_gaps = 1'b0;

    ide_interface_rom_paging #(
        .RAM_PAGES(RAM_PAGES)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_operation         (i_operation),
        .i_control_value     (i_control_value),
        .i_automap_level     (i_automap_level),
        .i_port_low          (i_port_low),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_paged_in          (o_paged_in),
        .o_bank0_source      (o_bank0_source),
        .o_bank0_writable    (o_bank0_writable),
        .o_bank1_page        (o_bank1_page),
        .o_bank1_writable    (o_bank1_writable),
        .o_ide_register_index(o_ide_register_index),
        .o_ide_attached      (o_ide_attached),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    ide_interface_rom_paging_check #(
        .RAM_PAGES(RAM_PAGES)
    ) u_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_operation         (i_operation),
        .i_control_value     (i_control_value),
        .i_automap_level     (i_automap_level),
        .i_port_low          (i_port_low),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_paged_in          (o_paged_in),
        .i_bank0_source      (o_bank0_source),
        .i_bank0_writable    (o_bank0_writable),
        .i_bank1_page        (o_bank1_page),
        .i_bank1_writable    (o_bank1_writable),
        .i_ide_register_index(o_ide_register_index),
        .i_ide_attached      (o_ide_attached),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_error_count       (error_count),
        .o_pending           (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_word(input logic [2:0] op, input logic [7:0] cv,
                             input logic al, input logic [7:0] pl);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_control_value <= cv;
        i_automap_level <= al;
        i_port_low      <= pl;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random();
        int         pick;
        logic [2:0] op;
        logic [7:0] pl;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = OP_CTRL_WRITE;
        else if (pick < 50)
            op = OP_AUTOMAP;
        else if (pick < 57)
            op = OP_SOFT_RESET;
        else if (pick < 63)
            op = OP_HARD_RESET;
        else if (pick < 93)
            op = OP_PORT_DEC;
        else
            op = 3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
        if ($urandom_range(0, 1))
            pl = 8'hA3 + 8'($urandom_range(0, 6)) * 8'd4;
        else
            pl = 8'($urandom);
        send_word(op, 8'($urandom), 1'($urandom), pl);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic configure(input logic en, input logic wp);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ENABLED;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_WPROTECT;
        i_cfg_data  <= wp;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // output side: random stall per word, two long hold-offs to fill the block
    initial begin : sink
        int gap;
        int taken;
        taken = 0;
        i_out_stall <= 1'b0;
        forever begin
            if (taken == 250 || taken == 650) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int k;
        int p;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_operation     <= OP_CTRL_WRITE;
        i_control_value <= '0;
        i_automap_level <= 1'b0;
        i_port_low      <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_ENABLED;
        i_cfg_data      <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // enabled, no write protect: CONMEM, sticky MAPRAM, resets, decodes
        configure(1'b1, 1'b0);
        send_word(OP_CTRL_WRITE, 8'h00, 1'b0, 8'h00);
        send_word(OP_CTRL_WRITE, 8'h83, 1'b0, 8'hFF);
        send_word(OP_CTRL_WRITE, 8'hFF, 1'b1, 8'h00);
        send_word(OP_CTRL_WRITE, 8'h03, 1'b0, 8'hFF);
        send_word(OP_AUTOMAP, 8'hFF, 1'b1, 8'h00);
        send_word(OP_SOFT_RESET, 8'h00, 1'b1, 8'hFF);
        send_word(OP_AUTOMAP, 8'h00, 1'b1, 8'h00);
        send_word(OP_HARD_RESET, 8'hFF, 1'b0, 8'hFF);
        for (k = 0; k < 7; k++)
            send_word(OP_PORT_DEC, 8'($urandom), 1'($urandom), 8'hA3 + 8'(4 * k));
        send_word(OP_PORT_DEC, 8'h00, 1'b0, 8'h00);
        send_word(OP_PORT_DEC, 8'hFF, 1'b1, 8'hFF);
        send_word(OP_UNDEF_FIRST, 8'hFF, 1'b1, 8'hA3);
        send_word(OP_UNDEF_LAST, 8'h00, 1'b0, 8'hBF);
        drain();

        // disabled, write protect: ignored writes, unclaimed decode, resets
        configure(1'b0, 1'b1);
        send_word(OP_CTRL_WRITE, 8'h80, 1'b0, 8'h00);
        send_word(OP_AUTOMAP, 8'h00, 1'b1, 8'h00);
        send_word(OP_PORT_DEC, 8'h00, 1'b0, 8'hA3);
        send_word(OP_SOFT_RESET, 8'h00, 1'b0, 8'h00);
        send_word(3'(OP_UNDEF_FIRST + 3'd1), 8'h00, 1'b0, 8'h00);
        drain();

        for (p = 0; p < N_PHASES; p++) begin
            configure(PHASE_EN[p], PHASE_WP[p]);
            no_gaps = (p == 3);
            repeat (PHASE_WORDS) send_random();
            drain();
        end
        no_gaps = 1'b0;
        repeat (5) @(posedge i_clk);

        if (error_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/idrp_pkg.sv
rtl/idrp_ctrl.sv
rtl/idrp_map.sv
rtl/ide_interface_rom_paging.sv
sim/ide_interface_rom_paging_check.sv
sim/ide_interface_rom_paging_test.sv
